// ===== rtl/spq_pkg.sv =====
package spq_pkg;

    localparam int KEY_W       = 16;
    localparam int PAYLOAD_W   = 32;
    localparam int COUNT_OUT_W = 5;
    localparam int DEPTH_DEF   = 16;

    typedef enum logic [0:0] {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t              req_type;
        logic [KEY_W-1:0]       new_key;
        logic [PAYLOAD_W-1:0]   new_payload;
    } req_t;

    typedef struct packed {
        logic [KEY_W-1:0]       out_key;
        logic [PAYLOAD_W-1:0]   out_payload;
        status_t                status;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                   enq;
        logic                   deq;
        logic [KEY_W-1:0]       key;
        logic [PAYLOAD_W-1:0]   payload;
    } bcast_t;

endpackage

// ===== rtl/spq_cell.sv =====
module spq_cell (
    input  logic                          aclk,
    input  spq_pkg::bcast_t               bc,
    input  logic                          occupied,
    input  logic                          left_moves,
    input  logic [spq_pkg::KEY_W-1:0]     left_key,
    input  logic [spq_pkg::PAYLOAD_W-1:0] left_payload,
    input  logic [spq_pkg::KEY_W-1:0]     right_key,
    input  logic [spq_pkg::PAYLOAD_W-1:0] right_payload,
    output logic                          moves,
    output logic [spq_pkg::KEY_W-1:0]     key,
    output logic [spq_pkg::PAYLOAD_W-1:0] payload
);
    import spq_pkg::*;

    logic [KEY_W-1:0]     key_reg;
    logic [PAYLOAD_W-1:0] payload_reg;

    // Slot is empty or holds a strictly larger key: new entry goes here or earlier.
    assign moves   = !occupied || (key_reg > bc.key);
    assign key     = key_reg;
    assign payload = payload_reg;

    always_ff @(posedge aclk) begin
        if (bc.enq) begin
            if (left_moves) begin
                key_reg     <= left_key;
                payload_reg <= left_payload;
            end else if (moves) begin
                key_reg     <= bc.key;
                payload_reg <= bc.payload;
            end
        end else if (bc.deq) begin
            key_reg     <= right_key;
            payload_reg <= right_payload;
        end
    end

endmodule

// ===== rtl/sorted_priority_queue.sv =====
// Channel  | Ports                    | Direction | Payload
// request  | s_valid, s_ready, s_req  | in        | req_t (req_type, new_key, new_payload)
// response | m_valid, m_ready, m_rsp  | out       | rsp_t (out_key, out_payload, status, entry_count)
//
// One request per cycle while s_ready is high: every cell compares its key with the
// new key in the same cycle and the whole chain shifts at once, and the response
// sits in the output register the cycle after the request is accepted.
// Reset (aresetn low, synchronous) empties the queue; the cells keep their data.
// s_ready is high while the output register is free or being drained.
module sorted_priority_queue #(
    parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  spq_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output spq_pkg::rsp_t m_rsp
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CNT_X = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 m_valid_reg;
    rsp_t                 m_rsp_reg, rsp_next;

    logic                 accept, is_enq, is_deq, full, empty;
    bcast_t               bc;
    logic [CNT_X-1:0]     count_ext;

    // Chain wiring; the end cells are tied off inside the generate loop.
    logic                 moves   [DEPTH];
    logic [KEY_W-1:0]     keys    [DEPTH];
    logic [PAYLOAD_W-1:0] pays    [DEPTH];

    assign accept = s_valid && s_ready;
    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign is_enq = (s_req.req_type == REQ_ENQ);
    assign is_deq = (s_req.req_type == REQ_DEQ);

    always_comb begin
        bc.enq     = accept && is_enq && !full;
        bc.deq     = accept && is_deq && !empty;
        bc.key     = s_req.new_key;
        bc.payload = s_req.new_payload;
    end

    generate
        for (genvar i = 0; i < DEPTH; i++) begin : g_cell
            logic                 l_moves;
            logic [KEY_W-1:0]     l_key, r_key;
            logic [PAYLOAD_W-1:0] l_pay, r_pay;

            if (i == 0) begin : g_head
                assign l_moves = 1'b0;
                assign l_key   = '0;
                assign l_pay   = '0;
            end else begin : g_mid
                assign l_moves = moves[i-1];
                assign l_key   = keys[i-1];
                assign l_pay   = pays[i-1];
            end

            if (i == DEPTH - 1) begin : g_tail
                // Tail slot becomes unused after a dequeue, so its data is don't-care.
                assign r_key = '0;
                assign r_pay = '0;
            end else begin : g_body
                assign r_key = keys[i+1];
                assign r_pay = pays[i+1];
            end

            spq_cell u_cell (
                .aclk          (aclk),
                .bc            (bc),
                .occupied      (count_reg > CNT_W'(i)),
                .left_moves    (l_moves),
                .left_key      (l_key),
                .left_payload  (l_pay),
                .right_key     (r_key),
                .right_payload (r_pay),
                .moves         (moves[i]),
                .key           (keys[i]),
                .payload       (pays[i])
            );
        end
    endgenerate

    always_comb begin
        count_next = count_reg;
        if (bc.enq) begin
            count_next = count_reg + 1'b1;
        end else if (bc.deq) begin
            count_next = count_reg - 1'b1;
        end
    end

    assign count_ext = CNT_X'(count_next);

    always_comb begin
        rsp_next             = '0;
        rsp_next.entry_count = count_ext[COUNT_OUT_W-1:0];
        if (is_deq) begin
            if (empty) begin
                rsp_next.status = ST_EMPTY;
            end else begin
                rsp_next.status      = ST_DONE;
                rsp_next.out_key     = keys[0];
                rsp_next.out_payload = pays[0];
            end
        end else begin
            rsp_next.status = full ? ST_FULL : ST_DONE;
        end
    end

    assign s_ready = !m_valid_reg || m_ready;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_rsp_reg <= rsp_next;
        end
    end

    // Count never runs past the chain length.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count exceeds depth");

    // Enqueue into a full queue is refused and the count holds.
    a_full_refuse: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_enq && full |=> m_valid && (m_rsp.status == ST_FULL) &&
        (count_reg == CNT_W'(DEPTH)))
        else $error("full enqueue not refused");

    // A successful dequeue removes exactly one entry.
    a_deq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_deq && !empty |=> (count_reg + 1'b1) == $past(count_reg))
        else $error("dequeue count mismatch");

    // Head two entries stay in order.
    a_head_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (keys[0] <= keys[1]))
        else $error("queue head out of order");

    // Dequeue of an empty queue returns zero data.
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && is_deq && empty |=> (m_rsp.status == ST_EMPTY) &&
        (m_rsp.out_key == '0) && (m_rsp.out_payload == '0))
        else $error("empty dequeue returned data");

endmodule
